/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL of the dual motor position controller.
// Both macros clock on clk; the first one is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is ignored while reset is asserted.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds across reset.
`define ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/dmpc_pkg.sv */
// Package of the dual motor PI position controller: widths, register codes,
// reset values and the configuration record. No dependencies.
`default_nettype none

package dmpc_pkg;

  // Default position width and fixed field widths.
  localparam int POSITION_WIDTH_DEF = 16;
  localparam int SPEED_W            = 11;
  localparam int KGAIN_W            = 9;
  localparam int BGAIN_W            = 12;
  localparam int DUTY_W             = 16;
  localparam int INTEG_W            = 20;
  localparam int LIM_W              = 12;
  localparam int OUT_W              = 13;

  // Control constants.
  localparam int FULL_DUTY  = 3200;
  localparam int FULL_SPEED = 1024;
  localparam int DEADBAND   = 20;
  localparam int INTEG_MAX  = 524287;
  localparam int INTEG_MIN  = -524288;

  // The limit is speed * 3200 / 1024, which is speed * 25 / 8.
  localparam int LIM_SHIFT = 3;
  localparam int LIM_MUL   = (FULL_DUTY << LIM_SHIFT) / FULL_SPEED;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN_A   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN_B   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOOST_GAIN_A  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOOST_GAIN_B  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CUT_GAIN_A    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CUT_GAIN_B    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_OFFSET   = 3'd7;

  // All configuration registers, as seen by the datapath.
  typedef struct packed {
    logic signed [KGAIN_W-1:0] prop_gain_a;
    logic signed [KGAIN_W-1:0] prop_gain_b;
    logic signed [KGAIN_W-1:0] integral_gain;
    logic [BGAIN_W-1:0]        boost_gain_a;
    logic [BGAIN_W-1:0]        boost_gain_b;
    logic [BGAIN_W-1:0]        cut_gain_a;
    logic [BGAIN_W-1:0]        cut_gain_b;
    logic [DUTY_W-1:0]         duty_offset;
  } dmpc_cfg_t;

  localparam dmpc_cfg_t CFG_RESET = '{
    prop_gain_a:   9'h1EC,
    prop_gain_b:   9'h1EC,
    integral_gain: 9'h000,
    boost_gain_a:  12'd512,
    boost_gain_b:  12'd333,
    cut_gain_a:    12'd256,
    cut_gain_b:    12'd128,
    duty_offset:   16'd24000
  };

endpackage

`default_nettype wire

/* hdl/dual_motor_pi_position_control.sv */
// Dual motor PI position controller, top level.
// Input channel: one beat per control tick. in_tdata holds, from bit 0 up,
// target_a, target_b, count_a, count_b (POSITION_WIDTH bits each, signed) and
// speed_setting (11 bits), zero padded to whole bytes; in_tuser[0] is
// stop_request. Output channel: out_tdata holds duty_a then duty_b (16 bits
// each); out_tuser holds drive_on_a then drive_on_b.
// Configuration: cfg_index selects one of eight gain/offset registers and
// cfg_data carries its value; cfg_ready is always high.
// Sequence: each tick runs up to seven products through one shared multiplier,
// each with an operand select state, then a write-back state. The result is
// offered after the last write-back; the balancing product is skipped when no
// channel needs balancing. in_tready is low while a tick is in progress, so no
// new beat is taken until the tick ends. The result sits in an output register:
// the next beat may be accepted while it waits, and the sequencer only holds at
// its last step if the previous result is still untaken.
// Reset (rst_n low, synchronous) restores the default gains, clears both
// integrators, resets the stored error ratio to 0/1 and empties the output.
`default_nettype none

module dual_motor_pi_position_control import dmpc_pkg::*; #(
  parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  // target_a, target_b, count_a, count_b, speed_setting, zero padding
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [((4*POSITION_WIDTH+SPEED_W+7)/8)*8-1:0] in_tdata,
  // stop_request
  input  logic [0:0] in_tuser,
  // duty_a, duty_b
  output logic out_tvalid,
  input  logic out_tready,
  output logic [2*DUTY_W-1:0] out_tdata,
  // drive_on_a, drive_on_b
  output logic [1:0] out_tuser,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "assert_macros.svh"

  localparam int PW     = POSITION_WIDTH;
  localparam int EW     = PW + 1;
  localparam int MW     = (PW + 2 > OUT_W + 1) ? PW + 2 : OUT_W + 1;
  localparam int PROD_W = 2 * MW;
  localparam int SW     = PROD_W + 1;

  localparam logic signed [SW-1:0] IMAX = SW'(INTEG_MAX);
  localparam logic signed [SW-1:0] IMIN = SW'(INTEG_MIN);

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WB, ST_DONE} state_t;
  typedef enum logic [2:0] {
    STP_IA, STP_IB, STP_PA, STP_PB, STP_LHS, STP_RHS, STP_BAL
  } step_t;

  // Saturate offset plus output to the duty range.
  function automatic logic [DUTY_W-1:0] sat_duty(input logic [DUTY_W-1:0] off,
                                                 input logic signed [OUT_W-1:0] o);
    logic signed [DUTY_W+1:0] s;
    begin
      s = $signed({2'b00, off}) + (DUTY_W+2)'(o);
      if (s[DUTY_W+1]) begin
        sat_duty = '0;
      end else if (s[DUTY_W]) begin
        sat_duty = '1;
      end else begin
        sat_duty = s[DUTY_W-1:0];
      end
    end
  endfunction

  dmpc_cfg_t cfg;

  state_t state_r;
  step_t  step_r;

  logic signed [EW-1:0]      ea_r, eb_r, num_r, den_r;
  logic [PW-1:0]             last_tb_r;
  logic [LIM_W-1:0]          lim_r;
  logic                      stop_r;
  logic signed [INTEG_W-1:0] integ_a_r, integ_b_r;
  logic signed [OUT_W-1:0]   oa_r, ob_r;
  logic signed [PROD_W-1:0]  lhs_r;
  logic                      bal_b_r;
  logic [BGAIN_W-1:0]        bal_gain_r;
  logic                      out_tvalid_r;
  logic [2*DUTY_W-1:0]       out_tdata_r;
  logic [1:0]                out_tuser_r;

  logic signed [PROD_W-1:0]  prod_r;

  // Configuration registers.
  dmpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_r     (cfg)
  );

  // Input fields and the values formed in the accept cycle.
  logic signed [PW-1:0] ta, tb, ca, cb;
  logic [SPEED_W-1:0]   spd, spd_sat;
  logic [LIM_W+3:0]     lim_prod;
  logic signed [EW-1:0] ea_in, eb_in;

  assign ta  = in_tdata[PW-1:0];
  assign tb  = in_tdata[2*PW-1:PW];
  assign ca  = in_tdata[3*PW-1:2*PW];
  assign cb  = in_tdata[4*PW-1:3*PW];
  assign spd = in_tdata[4*PW+SPEED_W-1:4*PW];

  assign spd_sat  = (spd > SPEED_W'(FULL_SPEED)) ? SPEED_W'(FULL_SPEED) : spd;
  assign lim_prod = (LIM_W+4)'(spd_sat) * (LIM_W+4)'(LIM_MUL);
  assign ea_in    = EW'(ta) - EW'(ca);
  assign eb_in    = EW'(tb) - EW'(cb);

  // Error magnitudes for the lag test and the deadband.
  logic [EW-1:0] ea_mag, eb_mag, num_mag, den_mag;

  assign ea_mag  = ea_r[EW-1]  ? EW'(-ea_r)  : EW'(ea_r);
  assign eb_mag  = eb_r[EW-1]  ? EW'(-eb_r)  : EW'(eb_r);
  assign num_mag = num_r[EW-1] ? EW'(-num_r) : EW'(num_r);
  assign den_mag = den_r[EW-1] ? EW'(-den_r) : EW'(den_r);

  // Operand select for the shared multiplier.
  logic signed [MW-1:0] op_a, op_b;

  always_comb begin
    unique case (step_r)
      STP_IA: begin
        op_a = MW'(cfg.integral_gain);
        op_b = MW'(ea_r);
      end
      STP_IB: begin
        op_a = MW'(cfg.integral_gain);
        op_b = MW'(eb_r);
      end
      STP_PA: begin
        op_a = MW'(cfg.prop_gain_a);
        op_b = MW'(ea_r);
      end
      STP_PB: begin
        op_a = MW'(cfg.prop_gain_b);
        op_b = MW'(eb_r);
      end
      STP_LHS: begin
        op_a = $signed(MW'({1'b0, ea_mag}));
        op_b = $signed(MW'({1'b0, den_mag}));
      end
      STP_RHS: begin
        op_a = $signed(MW'({1'b0, eb_mag}));
        op_b = $signed(MW'({1'b0, num_mag}));
      end
      STP_BAL: begin
        op_a = bal_b_r ? MW'(ob_r) : MW'(oa_r);
        op_b = $signed(MW'({1'b0, bal_gain_r}));
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  dmpc_mul #(.MUL_W(MW)) u_mul (
    .clk    (clk),
    .mul_en (state_r == ST_ISSUE),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  // Write-back arithmetic on the registered product.
  logic signed [PROD_W-1:0]  prod_q8;
  logic signed [INTEG_W-1:0] integ_sel, integ_new;
  logic signed [SW-1:0]      integ_sum, clamp_in, lim_s;
  logic signed [OUT_W-1:0]   clamp_out, lim_o, oa_mag, ob_mag;
  logic                      oa_at_lim, ob_at_lim, lhs_gt, rhs_gt;

  assign prod_q8   = prod_r >>> 8;
  assign integ_sel = (step_r == STP_IA || step_r == STP_PA) ? integ_a_r : integ_b_r;
  assign integ_sum = SW'(prod_q8) + SW'(integ_sel);

  // Integrator saturation.
  always_comb begin
    if (integ_sum > IMAX) begin
      integ_new = INTEG_W'(IMAX);
    end else if (integ_sum < IMIN) begin
      integ_new = INTEG_W'(IMIN);
    end else begin
      integ_new = INTEG_W'(integ_sum);
    end
  end

  // Clamp to the speed limit, for the PI sum and for the balanced output.
  assign lim_s    = $signed(SW'({1'b0, lim_r}));
  assign lim_o    = $signed(OUT_W'({1'b0, lim_r}));
  assign clamp_in = (step_r == STP_BAL) ? SW'(prod_q8) : SW'(prod_r) + SW'(integ_sel);

  always_comb begin
    if (clamp_in > lim_s) begin
      clamp_out = lim_o;
    end else if (clamp_in < -lim_s) begin
      clamp_out = -lim_o;
    end else begin
      clamp_out = OUT_W'(clamp_in);
    end
  end

  // Lag test and the at-limit check of each channel.
  assign oa_mag    = oa_r[OUT_W-1] ? -oa_r : oa_r;
  assign ob_mag    = ob_r[OUT_W-1] ? -ob_r : ob_r;
  assign oa_at_lim = oa_mag >= lim_o;
  assign ob_at_lim = ob_mag >= lim_o;
  assign lhs_gt    = lhs_r > prod_r;
  assign rhs_gt    = prod_r > lhs_r;

  // Sequencer, state and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= STP_IA;
      integ_a_r    <= '0;
      integ_b_r    <= '0;
      num_r        <= '0;
      den_r        <= EW'(1);
      last_tb_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // A taken result empties the output unless a new one replaces it now.
      if (out_tvalid_r && out_tready && state_r != ST_DONE) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            ea_r      <= ea_in;
            eb_r      <= eb_in;
            lim_r     <= lim_prod[LIM_W+LIM_SHIFT-1:LIM_SHIFT];
            stop_r    <= in_tuser[0];
            last_tb_r <= tb;
            if (tb != last_tb_r) begin
              num_r <= ea_in;
              den_r <= eb_in;
            end
            step_r  <= STP_IA;
            state_r <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          state_r <= ST_WB;
        end
        ST_WB: begin
          unique case (step_r)
            STP_IA: begin
              integ_a_r <= integ_new;
              step_r    <= STP_IB;
              state_r   <= ST_ISSUE;
            end
            STP_IB: begin
              integ_b_r <= integ_new;
              step_r    <= STP_PA;
              state_r   <= ST_ISSUE;
            end
            STP_PA: begin
              oa_r    <= clamp_out;
              step_r  <= STP_PB;
              state_r <= ST_ISSUE;
            end
            STP_PB: begin
              ob_r    <= clamp_out;
              step_r  <= STP_LHS;
              state_r <= ST_ISSUE;
            end
            STP_LHS: begin
              lhs_r   <= prod_r;
              step_r  <= STP_RHS;
              state_r <= ST_ISSUE;
            end
            STP_RHS: begin
              step_r <= STP_BAL;
              if (lhs_gt) begin
                // A lags: boost A, or cut B when A is already at the limit.
                bal_b_r    <= oa_at_lim;
                bal_gain_r <= oa_at_lim ? cfg.cut_gain_b : cfg.boost_gain_a;
                state_r    <= ST_ISSUE;
              end else if (rhs_gt) begin
                // B lags: boost B, or cut A when B is already at the limit.
                bal_b_r    <= !ob_at_lim;
                bal_gain_r <= ob_at_lim ? cfg.cut_gain_a : cfg.boost_gain_b;
                state_r    <= ST_ISSUE;
              end else begin
                state_r <= ST_DONE;
              end
            end
            STP_BAL: begin
              if (bal_b_r) begin
                ob_r <= clamp_out;
              end else begin
                oa_r <= clamp_out;
              end
              state_r <= ST_DONE;
            end
            default: begin
              state_r <= ST_IDLE;
            end
          endcase
        end
        ST_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {sat_duty(cfg.duty_offset, ob_r),
                             sat_duty(cfg.duty_offset, oa_r)};
            out_tuser_r  <= {!stop_r && (eb_mag >= EW'(DEADBAND)),
                             !stop_r && (ea_mag >= EW'(DEADBAND))};
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // A tick in progress blocks the input channel.
  `ASSERT_CLK(a_busy_after_accept, (in_tvalid && in_tready) |=> !in_tready, "beat accepted while busy")
  // The balancing product is the last step of a tick.
  `ASSERT_CLK(a_bal_is_last, (state_r == ST_WB && step_r == STP_BAL) |=> (state_r == ST_DONE), "sequencer ran past balancing")
  // Both outputs are within the speed limit when the duties are formed.
  `ASSERT_CLK(a_out_in_limit, (state_r == ST_DONE) |-> (oa_r <= lim_o && oa_r >= -lim_o && ob_r <= lim_o && ob_r >= -lim_o), "output outside limit")
  // Reset empties the output register.
  `ASSERT_RST(a_reset_empties_out, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

`default_nettype wire

/* hdl/dmpc_cfg_regs.sv */
// Configuration register file of the dual motor PI position controller.
// Depends on dmpc_pkg for the register codes, reset values and record type.
`default_nettype none

module dmpc_cfg_regs import dmpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output dmpc_cfg_t             cfg_r
);

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  // Register decode and write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PROP_GAIN_A:   cfg_r.prop_gain_a   <= cfg_data[KGAIN_W-1:0];
        REG_PROP_GAIN_B:   cfg_r.prop_gain_b   <= cfg_data[KGAIN_W-1:0];
        REG_INTEGRAL_GAIN: cfg_r.integral_gain <= cfg_data[KGAIN_W-1:0];
        REG_BOOST_GAIN_A:  cfg_r.boost_gain_a  <= cfg_data[BGAIN_W-1:0];
        REG_BOOST_GAIN_B:  cfg_r.boost_gain_b  <= cfg_data[BGAIN_W-1:0];
        REG_CUT_GAIN_A:    cfg_r.cut_gain_a    <= cfg_data[BGAIN_W-1:0];
        REG_CUT_GAIN_B:    cfg_r.cut_gain_b    <= cfg_data[BGAIN_W-1:0];
        REG_DUTY_OFFSET:   cfg_r.duty_offset   <= cfg_data[DUTY_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/dmpc_mul.sv */
// Shared signed multiplier of the dual motor PI position controller.
// The product is registered; the sequencer in the top level drives it.
`default_nettype none

module dmpc_mul import dmpc_pkg::*; #(
  parameter int MUL_W = POSITION_WIDTH_DEF + 2
) (
  input  logic                        clk,
  input  logic                        mul_en,
  input  logic signed [MUL_W-1:0]     op_a,
  input  logic signed [MUL_W-1:0]     op_b,
  output logic signed [2*MUL_W-1:0]   prod_r
);

  // One signed product per enabled cycle.
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= (2*MUL_W)'(op_a) * (2*MUL_W)'(op_b);
    end
  end

endmodule

`default_nettype wire
